// File: hw/rtl/tcm_pkg.sv
// Shared widths, opcodes and inter-module structs for the transitive closure block.
package tcm_pkg;

	localparam int ROW_W           = 32;  // bits in one ancestor row
	localparam int COL_W           = 5;   // column index width
	localparam int CNT_W           = 6;   // class count width
	localparam int ROW_LIMIT       = 32;  // rows never exceed the row width
	localparam int DEF_MAX_CLASSES = 32;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_EDGE  = 2'd1,
		OP_CLOSE = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Broadcast command from the controller to every cell.
	typedef struct packed {
		logic             clear;
		logic             set;
		logic [COL_W-1:0] col;
	} cell_ctl_t;

	// Pivot row travelling down the cell chain.
	typedef struct packed {
		logic             valid;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] bits;
	} pivot_tok_t;

endpackage

// File: hw/rtl/tcm_if.sv
// Valid/ready channel interfaces for operation input and row output.
interface tcm_in_if
	import tcm_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [1:0]       op;
	logic [COL_W-1:0] child_index;
	logic [COL_W-1:0] parent_index;

	modport source (output valid, output op, output child_index, output parent_index,
		input ready);
	modport sink (input valid, input op, input child_index, input parent_index,
		output ready);
endinterface

interface tcm_out_if
	import tcm_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [COL_W-1:0] row_class;
	logic [ROW_W-1:0] ancestor_bits;
	logic             last_row;
	logic             edge_error;

	modport source (output valid, output row_class, output ancestor_bits, output last_row,
		output edge_error, input ready);
	modport sink (input valid, input row_class, input ancestor_bits, input last_row,
		input edge_error, output ready);
endinterface

// File: hw/rtl/tcm_cell.sv
// One matrix row: holds the ancestor bits of a class and forwards the pivot row.
module tcm_cell
	import tcm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic             sel,
	input  logic             active,
	input  pivot_tok_t       tok_in,
	output pivot_tok_t       tok_out,
	output logic [ROW_W-1:0] row
);

	logic [ROW_W-1:0] row_q;
	logic             tok_valid_q;
	logic [COL_W-1:0] tok_col_q;
	logic [ROW_W-1:0] tok_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			tok_valid_q <= 1'b0;
		end else begin
			// A token stops at the first inactive cell, so none outlives its close run.
			tok_valid_q <= tok_in.valid && active;
			if (ctl.clear) begin
				row_q <= '0;
			end else if (ctl.set && sel) begin
				row_q[ctl.col] <= 1'b1;
			end else if (tok_in.valid && active && row_q[tok_in.col]) begin
				// This class reaches the pivot, so it inherits the pivot's ancestors.
				row_q <= row_q | tok_in.bits;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_col_q  <= tok_in.col;
		tok_bits_q <= tok_in.bits;
	end

	assign tok_out.valid = tok_valid_q;
	assign tok_out.col   = tok_col_q;
	assign tok_out.bits  = tok_bits_q;
	assign row           = row_q;

endmodule

// File: hw/rtl/transitive_closure_matrix.sv
// Top level: Warshall closure over a chain of row cells, with op decode and row output.
//
//  channel  | dir | transfer moves
//  ---------+-----+--------------------------------------------------
//  in_ch    | in  | op, child_index, parent_index
//  out_ch   | out | row_class, ancestor_bits, last_row, edge_error
//  cfg      | in  | class_count write (cfg_wr_en, cfg_wr_data)
//
// Clear and edge items are applied at their input transfer; an out-of-range edge also fills the output register.
// A close item first runs the closure over n classes, where n is the active class count: each
// pivot row is injected at the head of the cell chain and moves one cell per cycle.
// It then emits n rows, one per cycle while the output side keeps taking them.
// Reset clears the matrix and sets class_count to 32. Input is stalled while a close item runs
// its closure or emits its rows, and while the output register holds a result that is not being taken.
module transitive_closure_matrix
	import tcm_pkg::*;
#(
	parameter int MAX_CLASSES = DEF_MAX_CLASSES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data,
	tcm_in_if.sink           in_ch,
	tcm_out_if.source        out_ch
);

	localparam int ROWS  = (MAX_CLASSES < ROW_LIMIT) ? MAX_CLASSES : ROW_LIMIT;
	localparam int IDX_W = $clog2(ROWS);
	localparam logic [CNT_W-1:0] ROWS_CNT = CNT_W'(ROWS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLOSE,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] pivot_q;
	logic [IDX_W-1:0] row_ctr_q;
	logic [CNT_W-1:0] class_count_q;

	logic             out_valid_q;
	logic [COL_W-1:0] out_class_q;
	logic [ROW_W-1:0] out_bits_q;
	logic             out_last_q;
	logic             out_err_q;

	logic [CNT_W-1:0] n_cnt;
	logic [CNT_W-1:0] n_last;
	logic [ROW_W-1:0] col_mask;
	logic             out_free;
	logic             in_fire;
	logic             edge_ok;
	op_t              op;
	logic             pivot_done;
	logic             row_done;
	logic [IDX_W-1:0] rd_addr;
	logic [ROW_W-1:0] rd_row;

	cell_ctl_t        ctl;
	pivot_tok_t       inject;
	pivot_tok_t       chain [ROWS];
	logic [ROW_W-1:0] rows  [ROWS];

	assign n_cnt    = (class_count_q > ROWS_CNT) ? ROWS_CNT : class_count_q;
	assign n_last   = n_cnt - CNT_W'(1);
	assign col_mask = (n_cnt >= CNT_W'(ROW_W)) ? '1
		: ((ROW_W'(1) << n_cnt) - ROW_W'(1));

	assign out_free    = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && out_free;
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign op          = op_t'(in_ch.op);
	assign edge_ok     = ({1'b0, in_ch.child_index} < n_cnt)
		&& ({1'b0, in_ch.parent_index} < n_cnt);

	assign row_done   = (CNT_W'(row_ctr_q) == n_last);
	assign pivot_done = (CNT_W'(pivot_q) == n_last);

	// One read port: the pivot row during the closure, the emitted row afterwards.
	assign rd_addr = (state_q == ST_EMIT) ? row_ctr_q : pivot_q;
	assign rd_row  = rows[rd_addr];

	always_comb begin
		ctl.clear = in_fire && (op == OP_CLEAR);
		ctl.set   = in_fire && (op == OP_EDGE) && edge_ok;
		ctl.col   = in_ch.parent_index;
	end

	always_comb begin
		inject.valid = (state_q == ST_CLOSE) && (row_ctr_q == '0);
		inject.col   = COL_W'(pivot_q);
		inject.bits  = rd_row & col_mask;
	end

	for (genvar i = 0; i < ROWS; i++) begin : g_cell
		logic sel;
		logic active;

		assign sel    = (in_ch.child_index[IDX_W-1:0] == IDX_W'(i));
		assign active = (CNT_W'(i) < n_cnt);

		if (i == 0) begin : g_head
			tcm_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.sel     (sel),
				.active  (active),
				.tok_in  (inject),
				.tok_out (chain[i]),
				.row     (rows[i])
			);
		end else begin : g_body
			tcm_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.sel     (sel),
				.active  (active),
				.tok_in  (chain[i-1]),
				.tok_out (chain[i]),
				.row     (rows[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q <= CNT_W'(ROW_W);
		end else if (cfg_wr_en) begin
			class_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pivot_q     <= '0;
			row_ctr_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						unique case (op)
							OP_EDGE: begin
								if (!edge_ok) begin
									out_valid_q <= 1'b1;
									out_class_q <= in_ch.child_index;
									out_bits_q  <= '0;
									out_last_q  <= 1'b0;
									out_err_q   <= 1'b1;
								end
							end
							OP_CLOSE: begin
								if (n_cnt != '0) begin
									state_q   <= ST_CLOSE;
									pivot_q   <= '0;
									row_ctr_q <= '0;
								end
							end
							OP_CLEAR, OP_NONE: begin
							end
							default: begin
							end
						endcase
					end
				end
				ST_CLOSE: begin
					// The row counter holds each pivot until its row has passed every active cell.
					if (row_done) begin
						row_ctr_q <= '0;
						if (pivot_done) begin
							pivot_q <= '0;
							state_q <= ST_EMIT;
						end else begin
							pivot_q <= pivot_q + IDX_W'(1);
						end
					end else begin
						row_ctr_q <= row_ctr_q + IDX_W'(1);
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_class_q <= COL_W'(row_ctr_q);
						out_bits_q  <= rd_row & col_mask;
						out_last_q  <= row_done;
						out_err_q   <= 1'b0;
						if (row_done) begin
							row_ctr_q <= '0;
							state_q   <= ST_IDLE;
						end else begin
							row_ctr_q <= row_ctr_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.row_class     = out_class_q;
	assign out_ch.ancestor_bits = out_bits_q;
	assign out_ch.last_row      = out_last_q;
	assign out_ch.edge_error    = out_err_q;

	// No result can be pending while the closure itself runs.
	a_close_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLOSE) |-> !out_valid_q)
		else $error("result pending during closure");

	// Emission never walks past the active rows.
	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (CNT_W'(row_ctr_q) < n_cnt))
		else $error("emit row counter out of range");

	// Once the final row is loaded the block is back in idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> (state_q == ST_IDLE))
		else $error("last row shown while close run still active");

	// A pivot is only injected at the start of its pass through the chain.
	a_inject_start: assert property (@(posedge clk) disable iff (!arst_n)
		inject.valid |=> (state_q != ST_CLOSE) || (row_ctr_q != '0) || (n_cnt == CNT_W'(1)))
		else $error("pivot injected twice in one pass");

endmodule
